// ===== rtl/kagi_pkg.sv =====
package kagi_pkg;

    localparam int PRICE_W          = 48;
    localparam int STAMP_W          = 63;
    localparam int HELD_W           = 9;
    localparam int WINDOW_LINES_DEF = 256;

    // apb register map: a single 48-bit register in the lower 8-byte slot
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;
    localparam logic REG_REVERSAL = 1'b0;

    localparam logic [PRICE_W-1:0] REVERSAL_RESET = 48'd16777216;

    // request codes
    localparam logic REQ_PRICE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef logic [PRICE_W-1:0] t_price;
    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [HELD_W-1:0]  t_held;

    // sequencer to window store
    typedef struct packed {
        logic   clear;
        logic   push;
        t_price lo;
        t_price hi;
    } t_win_cmd;

    // window store back to sequencer
    typedef struct packed {
        logic   done;
        t_price wlo;
        t_price whi;
        t_held  held;
    } t_win_stat;

endpackage

// ===== rtl/kagi_if.sv =====
interface kagi_in_if;
    import kagi_pkg::*;

    logic   valid;
    logic   ready;
    logic   req_type;
    t_price price;
    t_stamp stamp;

    modport source (output valid, req_type, price, stamp, input ready);
    modport sink   (input valid, req_type, price, stamp, output ready);
endinterface

interface kagi_out_if;
    import kagi_pkg::*;

    logic   valid;
    logic   ready;
    t_price seg_start;
    t_price seg_end;
    t_price seg_high;
    t_price seg_low;
    logic   seg_rising;
    t_stamp seg_stamp;
    t_price window_low;
    t_price window_high;
    t_held  lines_held;

    modport source (output valid, seg_start, seg_end, seg_high, seg_low, seg_rising,
                    seg_stamp, window_low, window_high, lines_held, input ready);
    modport sink   (input valid, seg_start, seg_end, seg_high, seg_low, seg_rising,
                    seg_stamp, window_low, window_high, lines_held, output ready);
endinterface

// ===== rtl/kagi_cfg.sv =====
module kagi_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kagi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kagi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kagi_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [kagi_pkg::PRICE_W-1:0]    o_reversal
);
    import kagi_pkg::*;

    t_price r_reversal;
    logic   wr_en;
    logic   sel_rev;

    assign pready  = 1'b1;
    assign sel_rev = (paddr[APB_ADDR_W-1] == REG_REVERSAL);
    assign wr_en   = psel && penable && pwrite && sel_rev && (pwdata[PRICE_W-1:0] != '0);

    // reversal amount, a zero write keeps the old value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reversal <= REVERSAL_RESET;
        end else if (wr_en) begin
            r_reversal <= pwdata[PRICE_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (sel_rev) begin
            prdata = APB_DATA_W'(r_reversal);
        end
    end

    assign o_reversal = r_reversal;

endmodule

// ===== rtl/kagi_window.sv =====
module kagi_window #(
    parameter int WINDOW_LINES = kagi_pkg::WINDOW_LINES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kagi_pkg::t_win_cmd  i_cmd,
    output kagi_pkg::t_win_stat o_stat
);
    import kagi_pkg::*;

    localparam int AW = (WINDOW_LINES > 1) ? $clog2(WINDOW_LINES) : 1;
    localparam int CW = $clog2(WINDOW_LINES + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_LINES - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_LINES);
    localparam logic [CW:0]   WRAP_SUM  = (CW + 1)'(WINDOW_LINES);

    // ring storage of segment lows and highs
    t_price mem_lo [WINDOW_LINES];
    t_price mem_hi [WINDOW_LINES];

    logic [AW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_held, n_held;
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_issued;
    logic          r_scan;
    logic          r_dv;
    t_price        r_rd_lo, r_rd_hi;
    t_price        r_wlo, r_whi;

    logic [CW:0]   slot_sum;
    logic [AW-1:0] wr_slot;
    logic          rd_en;
    logic          full;

    // slot for the new segment and ring pointer update
    always_comb begin
        full     = (r_held == FULL_CNT);
        slot_sum = (CW + 1)'(r_oldest) + (CW + 1)'(r_held);
        if (slot_sum >= WRAP_SUM) begin
            slot_sum = slot_sum - WRAP_SUM;
        end
        n_oldest = r_oldest;
        n_held   = r_held;
        if (full) begin
            wr_slot  = r_oldest;
            n_oldest = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
        end else begin
            wr_slot  = slot_sum[AW-1:0];
            n_held   = r_held + 1'b1;
        end
    end

    assign rd_en = r_scan && (r_issued != r_held);

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem_lo[wr_slot] <= i_cmd.lo;
            mem_hi[wr_slot] <= i_cmd.hi;
        end
        if (rd_en) begin
            r_rd_lo <= mem_lo[r_ptr];
            r_rd_hi <= mem_hi[r_ptr];
        end
    end

    // ring control and scan sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_oldest <= '0;
            r_held   <= '0;
            r_scan   <= 1'b0;
            r_dv     <= 1'b0;
        end else if (i_cmd.push) begin
            r_oldest <= n_oldest;
            r_held   <= n_held;
            r_scan   <= 1'b1;
            r_dv     <= 1'b0;
        end else begin
            r_dv <= rd_en;
            if (o_stat.done) begin
                r_scan <= 1'b0;
            end
        end
    end

    // scan pointer and running min / max
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_ptr    <= n_oldest;
            r_issued <= '0;
            r_wlo    <= '1;
            r_whi    <= '0;
        end else begin
            if (rd_en) begin
                r_ptr    <= (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
                r_issued <= r_issued + 1'b1;
            end
            if (r_dv) begin
                if (r_rd_lo < r_wlo) begin
                    r_wlo <= r_rd_lo;
                end
                if (r_rd_hi > r_whi) begin
                    r_whi <= r_rd_hi;
                end
            end
        end
    end

    assign o_stat.done = r_scan && !rd_en && !r_dv;
    assign o_stat.wlo  = r_wlo;
    assign o_stat.whi  = r_whi;
    assign o_stat.held = HELD_W'(r_held);

endmodule

// ===== rtl/kagi_line_builder.sv =====
// channel   dir  handshake      payload
// i_in      in   valid/ready    req_type, price, stamp
// o_out     out  valid/ready    segment, window low/high, lines held
// apb       in   psel/penable   reversal amount at byte address 0
//
// a price that makes a segment passes the transfer, the trend decision in
// ST_DIFF and ST_CMP (the segment is stored in ST_CMP), the window scan
// over every retained line, and ST_OUT with the result valid; a clear
// request stays in ST_IDLE, a price that makes no segment ends at ST_CMP
// i_in is not ready while an item is worked on or its result is not taken
// reset is synchronous: empty window, rising trend, reversal amount 1.0
module kagi_line_builder #(
    parameter int WINDOW_LINES = kagi_pkg::WINDOW_LINES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    kagi_in_if.sink                         i_in,
    kagi_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kagi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kagi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kagi_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import kagi_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    t_price     r_line;
    logic       r_trend;
    logic       r_seen;
    t_price     r_price;
    t_stamp     r_stamp;
    t_price     r_start;
    t_price     r_diff;
    logic       r_with;
    logic       r_rising;
    t_price     r_wlo, r_whi;
    t_held      r_held;

    t_price     reversal;
    t_price     start;
    logic [PRICE_W:0] diff;
    logic       emit;
    logic       rising;
    logic       accept;
    t_win_cmd   win_cmd;
    t_win_stat  win_stat;

    kagi_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_reversal (reversal)
    );

    kagi_window #(
        .WINDOW_LINES (WINDOW_LINES)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (win_cmd),
        .o_stat  (win_stat)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // trend difference: negative or zero means the price goes with the trend
    always_comb begin
        start = r_seen ? r_line : r_price;
        if (r_trend) begin
            diff = {1'b0, start} - {1'b0, r_price};
        end else begin
            diff = {1'b0, r_price} - {1'b0, start};
        end
    end

    // emit decision, a rising segment always ends at or above its start
    assign emit   = r_with || (r_diff >= reversal);
    assign rising = r_with ? r_trend : !r_trend;

    // window commands
    always_comb begin
        win_cmd.clear = accept && (i_in.req_type == REQ_CLEAR);
        win_cmd.push  = (r_state == ST_CMP) && emit;
        win_cmd.lo    = rising ? r_start : r_price;
        win_cmd.hi    = rising ? r_price : r_start;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_in.req_type == REQ_PRICE)) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: n_state = ST_CMP;
            ST_CMP:  n_state = emit ? ST_SCAN : ST_IDLE;
            ST_SCAN: begin
                if (win_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_line  <= '0;
            r_trend <= 1'b1;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (win_cmd.clear) begin
                r_line  <= '0;
                r_trend <= 1'b1;
                r_seen  <= 1'b0;
            end
            if (r_state == ST_DIFF) begin
                r_seen <= 1'b1;
            end
            if (win_cmd.push) begin
                r_line  <= r_price;
                r_trend <= rising;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_price <= i_in.price;
            r_stamp <= i_in.stamp;
        end
        if (r_state == ST_DIFF) begin
            r_start <= start;
            r_diff  <= diff[PRICE_W-1:0];
            r_with  <= diff[PRICE_W] || (diff[PRICE_W-1:0] == '0);
        end
        if (win_cmd.push) begin
            r_rising <= rising;
        end
        if ((r_state == ST_SCAN) && win_stat.done) begin
            r_wlo  <= win_stat.wlo;
            r_whi  <= win_stat.whi;
            r_held <= win_stat.held;
        end
    end

    // result transfer
    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.seg_start   = r_start;
    assign o_out.seg_end     = r_price;
    assign o_out.seg_high    = r_rising ? r_price : r_start;
    assign o_out.seg_low     = r_rising ? r_start : r_price;
    assign o_out.seg_rising  = r_rising;
    assign o_out.seg_stamp   = r_stamp;
    assign o_out.window_low  = r_wlo;
    assign o_out.window_high = r_whi;
    assign o_out.lines_held  = r_held;

endmodule

// ===== test/kagi_line_builder_tb.sv =====
`timescale 1ns / 1ps

module kagi_line_builder_tb;
    import kagi_pkg::*;

    localparam int WINDOW = WINDOW_LINES_DEF;
    localparam t_price PX_ONE = 48'h100_0000;
    localparam t_price PX_MAX = 48'hFFFF_FFFF_FFFF;
    localparam t_stamp STAMP_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [APB_ADDR_W-1:0] REVERSAL_ADDR = APB_ADDR_W'(8 * REG_REVERSAL);
    // first byte address past the register map
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(8 * (REG_REVERSAL + 1));
    localparam int QUIET_CYCLES = 8;
    localparam int SETTLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic   req_type;
        t_price price;
        t_stamp stamp;
    } t_tick;

    typedef struct packed {
        t_price seg_start;
        t_price seg_end;
        t_price seg_high;
        t_price seg_low;
        logic   seg_rising;
        t_stamp seg_stamp;
        t_price window_low;
        t_price window_high;
        t_held  lines_held;
    } t_seg;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    kagi_in_if  in_ch ();
    kagi_out_if seg_ch ();

    kagi_line_builder #(
        .WINDOW_LINES(WINDOW)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (seg_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and expected segments
    t_tick ticks_pending[$];
    t_seg  segments_due[$];
    int send_idle;
    int recv_idle;
    logic in_taken;
    int errors;
    int ticks_taken;
    int clears_taken;
    int segs_checked;
    int window_drops;
    int reversals;

    // predicted line state
    t_price reversal = REVERSAL_RESET;
    t_price line_px = '0;
    bit up_trend = 1'b1;
    bit started = 1'b0;
    t_price window_lows [WINDOW];
    t_price window_highs [WINDOW];
    int unsigned head_slot = 0;
    int unsigned kept = 0;

    t_tick tick_next;
    t_tick tick_seen;
    t_seg  seg_made;
    t_seg  seg_head;

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // advance the line by one request, return 1 when a segment comes out
    function automatic bit trace_line(input t_tick tick, output t_seg seg);
        t_price start;
        t_price lo;
        t_price hi;
        bit emit;
        bit rising;
        int unsigned slot;
        int unsigned n;
        emit = 1'b0;
        rising = 1'b0;
        seg = '0;
        if (tick.req_type == REQ_CLEAR) begin
            line_px = '0;
            up_trend = 1'b1;
            started = 1'b0;
            head_slot = 0;
            kept = 0;
            clears_taken++;
            return 1'b0;
        end
        if (!started) begin
            line_px = tick.price;
            started = 1'b1;
        end
        start = line_px;
        if (up_trend) begin
            if (tick.price >= start) begin
                emit = 1'b1;
                rising = 1'b1;
            end else if (start - tick.price >= reversal) begin
                emit = 1'b1;
                rising = 1'b0;
            end
        end else begin
            if (tick.price <= start) begin
                emit = 1'b1;
                rising = 1'b0;
            end else if (tick.price - start >= reversal) begin
                emit = 1'b1;
                rising = 1'b1;
            end
        end
        if (!emit)
            return 1'b0;
        if (rising != up_trend)
            reversals++;
        up_trend = rising;
        line_px = tick.price;
        hi = (start > tick.price) ? start : tick.price;
        lo = (start < tick.price) ? start : tick.price;
        // ring of segments, oldest dropped once full
        if (kept < WINDOW) begin
            slot = (head_slot + kept) % WINDOW;
            kept++;
        end else begin
            slot = head_slot;
            head_slot = (head_slot + 1) % WINDOW;
            window_drops++;
        end
        window_lows[slot] = lo;
        window_highs[slot] = hi;
        seg.window_low = PX_MAX;
        seg.window_high = '0;
        for (n = 0; n < kept; n++) begin
            slot = (head_slot + n) % WINDOW;
            if (window_lows[slot] < seg.window_low)
                seg.window_low = window_lows[slot];
            if (window_highs[slot] > seg.window_high)
                seg.window_high = window_highs[slot];
        end
        seg.seg_start = start;
        seg.seg_end = tick.price;
        seg.seg_high = hi;
        seg.seg_low = lo;
        seg.seg_rising = rising;
        seg.seg_stamp = tick.stamp;
        seg.lines_held = t_held'(kept);
        return 1'b1;
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (ticks_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                tick_next = ticks_pending.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.req_type <= tick_next.req_type;
                in_ch.price <= tick_next.price;
                in_ch.stamp <= tick_next.stamp;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        seg_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    // input transfers feed the prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                tick_seen.req_type = in_ch.req_type;
                tick_seen.price = in_ch.price;
                tick_seen.stamp = in_ch.stamp;
                ticks_taken++;
                if (trace_line(tick_seen, seg_made))
                    segments_due.push_back(seg_made);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && seg_ch.valid === 1'b1 && seg_ch.ready) begin
            if (segments_due.size() == 0) begin
                report_mismatch($sformatf("segment with none due, end %h stamp %h",
                                          seg_ch.seg_end, seg_ch.seg_stamp));
            end else begin
                seg_head = segments_due.pop_front();
                check_field("seg_start", seg_ch.seg_start, seg_head.seg_start);
                check_field("seg_end", seg_ch.seg_end, seg_head.seg_end);
                check_field("seg_high", seg_ch.seg_high, seg_head.seg_high);
                check_field("seg_low", seg_ch.seg_low, seg_head.seg_low);
                check_field("seg_rising", seg_ch.seg_rising, seg_head.seg_rising);
                check_field("seg_stamp", seg_ch.seg_stamp, seg_head.seg_stamp);
                check_field("window_low", seg_ch.window_low, seg_head.window_low);
                check_field("window_high", seg_ch.window_high, seg_head.window_high);
                check_field("lines_held", seg_ch.lines_held, seg_head.lines_held);
                segs_checked++;
            end
        end
    end

    function automatic t_stamp rand_stamp();
        return t_stamp'({$urandom, $urandom});
    endfunction

    task automatic queue_tick(input logic req, input t_price px, input t_stamp st);
        t_tick t;
        t.req_type = req;
        t.price = px;
        t.stamp = st;
        ticks_pending.push_back(t);
    endtask

    // one apb transfer, setup then access
    task automatic apb_cycle(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] wdata,
                             output logic [APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_reversal();
        logic [APB_DATA_W-1:0] rd;
        apb_cycle(1'b0, REVERSAL_ADDR, '0, rd);
        check_field("reversal_amount readback", 64'(rd[PRICE_W-1:0]), 64'(reversal));
    endtask

    task automatic program_reg(input logic [APB_ADDR_W-1:0] addr,
                               input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_cycle(1'b1, addr, value, rd);
        // zero and unmapped writes leave the register alone
        if (addr == REVERSAL_ADDR && value[PRICE_W-1:0] != '0)
            reversal = value[PRICE_W-1:0];
        check_reversal();
    endtask

    // wait until every due segment is out and the block is quiet
    task automatic settle();
        int waited;
        waited = 0;
        while ((ticks_pending.size() != 0 || in_ch.valid || segments_due.size() != 0)
               && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (segments_due.size() != 0)
            report_mismatch($sformatf("%0d segments never arrived", segments_due.size()));
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // random walk around the line, steps scaled to the reversal amount
    task automatic queue_walk(input int count, input int clear_per_mille);
        longint unsigned cur;
        longint unsigned mag;
        longint unsigned span;
        cur = {$urandom_range(0, 8191), 24'($urandom)};
        span = 3 * longint'(reversal) + 1;
        repeat (count) begin
            if ($urandom_range(0, 999) < clear_per_mille) begin
                queue_tick(REQ_CLEAR, t_price'({$urandom, $urandom}), rand_stamp());
            end else begin
                case ($urandom_range(0, 9))
                    0: mag = reversal - 1;
                    1: mag = reversal;
                    2: mag = 0;
                    default: mag = {$urandom} % span;
                endcase
                if ($urandom_range(0, 9) == 0)
                    cur = {$urandom, $urandom} & PX_MAX;
                else if ($urandom_range(0, 1))
                    cur = (cur > PX_MAX - mag) ? PX_MAX : cur + mag;
                else
                    cur = (mag > cur) ? 0 : cur - mag;
                queue_tick(REQ_PRICE, t_price'(cur), rand_stamp());
            end
        end
    endtask

    initial begin : stimulus
        errors = 0;
        ticks_taken = 0;
        clears_taken = 0;
        segs_checked = 0;
        window_drops = 0;
        reversals = 0;
        send_idle = 31;
        recv_idle = 72;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_PRICE;
        in_ch.price = '0;
        in_ch.stamp = '0;
        seg_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reversal();

        // trend moves at the reset reversal amount of 1.0
        @(posedge i_clk);
        queue_tick(REQ_PRICE, 10 * PX_ONE, '0);
        queue_tick(REQ_PRICE, 10 * PX_ONE, rand_stamp());
        queue_tick(REQ_PRICE, 12 * PX_ONE + PX_ONE / 2, rand_stamp());
        queue_tick(REQ_PRICE, 11 * PX_ONE + 3 * PX_ONE / 4, rand_stamp());
        queue_tick(REQ_PRICE, 11 * PX_ONE + PX_ONE / 2, rand_stamp());
        queue_tick(REQ_PRICE, 11 * PX_ONE + PX_ONE / 2, rand_stamp());
        queue_tick(REQ_PRICE, 9 * PX_ONE, rand_stamp());
        queue_tick(REQ_PRICE, 10 * PX_ONE - 1, rand_stamp());
        queue_tick(REQ_PRICE, 10 * PX_ONE, rand_stamp());
        queue_tick(REQ_PRICE, PX_MAX, STAMP_MAX);
        queue_tick(REQ_PRICE, '0, rand_stamp());
        queue_tick(REQ_CLEAR, PX_MAX, STAMP_MAX);
        queue_tick(REQ_PRICE, '0, STAMP_MAX);
        queue_tick(REQ_PRICE, '0, '0);
        queue_tick(REQ_CLEAR, '0, '0);
        queue_tick(REQ_CLEAR, '0, '0);
        settle();

        // ignored writes, then the largest reversal amount
        program_reg(REVERSAL_ADDR, '0);
        program_reg(UNUSED_ADDR, '1);
        program_reg(REVERSAL_ADDR, 64'(PX_MAX));
        @(posedge i_clk);
        queue_tick(REQ_PRICE, '0, rand_stamp());
        queue_tick(REQ_PRICE, PX_MAX, rand_stamp());
        queue_tick(REQ_PRICE, 48'd1, rand_stamp());
        queue_tick(REQ_PRICE, '0, rand_stamp());
        queue_tick(REQ_PRICE, PX_MAX - 1, rand_stamp());
        queue_tick(REQ_PRICE, PX_MAX, rand_stamp());
        settle();

        // half reversal, upper write bits set; sender waits out the pipe midway
        program_reg(REVERSAL_ADDR, {16'hA5A5, 48'h80_0000});
        @(posedge i_clk);
        queue_walk(175, 5);
        settle();
        @(posedge i_clk);
        queue_walk(175, 5);
        settle();

        send_idle = 72;
        recv_idle = 31;
        program_reg(REVERSAL_ADDR, 64'($urandom_range(1, 1 << 26)));
        @(posedge i_clk);
        queue_walk(350, 4);
        settle();

        // smallest reversal, no clears so the window wraps
        send_idle = 0;
        recv_idle = 0;
        program_reg(REVERSAL_ADDR, 64'd1);
        @(posedge i_clk);
        queue_walk(350, 0);
        settle();
        repeat (WINDOW + 16) @(posedge i_clk);

        $display("%0d transfers in (%0d clears), %0d segments checked, %0d reversals",
                 ticks_taken, clears_taken, segs_checked, reversals);
        $display("oldest line dropped %0d times from a full window", window_drops);
        if (errors == 0)
            $display("kagi_line_builder regression: pass");
        else
            $display("kagi_line_builder regression: fail");
        $finish;
    end

    initial begin : watchdog
        #25_000_000;
        $display("timeout with %0d segments still due", segments_due.size());
        $display("kagi_line_builder regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kagi_pkg.sv
rtl/kagi_if.sv
rtl/kagi_cfg.sv
rtl/kagi_window.sv
rtl/kagi_line_builder.sv
test/kagi_line_builder_tb.sv
